/* design/bnfa_pkg.sv */
// shared constants and types for the banked next-fit id allocator
package bnfa_pkg;

  localparam int IDS_PER_BANK_DEF = 128;
  localparam int BANKS_DEF        = 2;

  localparam int GROUP_W  = 8;
  localparam int GROUP_SH = 3;
  localparam int STATUS_W = 2;

  localparam logic OP_RESERVE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNUSED = 2'd2;

  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

endpackage

/* design/bnfa_ctrl.sv */
// request sequencer and output handshake for the id allocator
module bnfa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bnfa_pkg::ctrl_cmd_t  cmd_o
);
  import bnfa_pkg::*;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_COMMIT = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.commit = (state_q == S_COMMIT) && (!out_valid_q || !out_stall_i);
    state_d      = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (cmd_o.commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // one item in work at a time
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while another is in work");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("committed result not presented");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && state_q == S_COMMIT) |=> (state_q == S_COMMIT))
    else $error("commit while result stalled");

  a_commit_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> $past(cmd_o.load) || $past(state_q == S_COMMIT))
    else $error("commit without a loaded item");

endmodule

/* design/bnfa_datapath.sv */
// bitmaps, pointers, counts, free-id search and result registers
module bnfa_datapath #(
  parameter int  IDS_PER_BANK = bnfa_pkg::IDS_PER_BANK_DEF,
  parameter int  BANKS        = bnfa_pkg::BANKS_DEF,
  localparam int ID_W         = $clog2(IDS_PER_BANK),
  localparam int CNT_W        = ID_W + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bnfa_pkg::ctrl_cmd_t           cmd_i,
  input  logic                          operation_i,
  input  logic                          bank_i,
  input  logic [ID_W-1:0]               release_id_i,
  output logic [CNT_W-1:0]              granted_id_o,
  output logic [bnfa_pkg::STATUS_W-1:0] status_o,
  output logic [CNT_W-1:0]              in_use_count_o
);
  import bnfa_pkg::*;

  localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int NGRP   = (IDS_PER_BANK + GROUP_W - 1) / GROUP_W;
  localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD_W  = NGRP * GROUP_W;

  logic [IDS_PER_BANK-1:0] map_q [BANKS];
  logic [ID_W-1:0]         ptr_q [BANKS];
  logic [CNT_W-1:0]        cnt_q [BANKS];

  logic               op_q;
  logic [BANK_W-1:0]  bank_q;
  logic [ID_W-1:0]    rid_q;
  logic               found_q;
  logic [GRP_W-1:0]   grp_q;
  logic [GROUP_W-1:0] gbits_q;

  logic [CNT_W-1:0]    out_id_q, out_id_d;
  logic [STATUS_W-1:0] out_st_q, out_st_d;
  logic [CNT_W-1:0]    out_cnt_q;

  // search stage, evaluated on the accepted item
  logic [BANK_W-1:0]       bank_sel;
  logic [IDS_PER_BANK-1:0] row_s;
  logic [ID_W-1:0]         ptr_s;
  logic [PAD_W-1:0]        free_all, free_hi;
  logic [NGRP-1:0]         any_all, any_hi;
  logic [GRP_W-1:0]        grp_all, grp_hi, grp_s;
  logic                    use_hi, found_s;
  logic [GROUP_W-1:0]      gbits_s;
  logic [ID_W-1:0]         rid_s;
  logic [CNT_W-1:0]        rid_ext;

  always_comb begin
    bank_sel = (BANKS > 1) ? BANK_W'(bank_i) : '0;
    row_s    = map_q[bank_sel];
    ptr_s    = ptr_q[bank_sel];
    free_all = PAD_W'(~row_s);
    for (int i = 0; i < PAD_W; i++) begin
      free_hi[i] = free_all[i] && (i >= int'(ptr_s));
    end
    for (int g = 0; g < NGRP; g++) begin
      any_all[g] = |free_all[g*GROUP_W +: GROUP_W];
      any_hi[g]  = |free_hi[g*GROUP_W +: GROUP_W];
    end
    grp_all = '0;
    grp_hi  = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (any_all[g]) begin
        grp_all = GRP_W'(g);
      end
      if (any_hi[g]) begin
        grp_hi = GRP_W'(g);
      end
    end
    use_hi  = |any_hi;
    found_s = |any_all;
    grp_s   = use_hi ? grp_hi : grp_all;
    gbits_s = use_hi ? free_hi[grp_hi*GROUP_W +: GROUP_W]
                     : free_all[grp_all*GROUP_W +: GROUP_W];
    rid_ext = CNT_W'(release_id_i);
    if (rid_ext >= CNT_W'(IDS_PER_BANK)) begin
      rid_s = ID_W'(rid_ext - CNT_W'(IDS_PER_BANK));
    end else begin
      rid_s = release_id_i;
    end
  end

  // commit stage
  logic [IDS_PER_BANK-1:0] row_c, row_d;
  logic [CNT_W-1:0]        cnt_c, cnt_d;
  logic [ID_W-1:0]         ptr_d;
  logic [GROUP_SH-1:0]     off;
  logic [ID_W-1:0]         id_c;

  always_comb begin
    row_c = map_q[bank_q];
    cnt_c = cnt_q[bank_q];
    off   = '0;
    for (int k = GROUP_W - 1; k >= 0; k--) begin
      if (gbits_q[k]) begin
        off = GROUP_SH'(k);
      end
    end
    id_c     = ID_W'({grp_q, off});
    row_d    = row_c;
    cnt_d    = cnt_c;
    ptr_d    = ptr_q[bank_q];
    out_id_d = CNT_W'(rid_q);
    out_st_d = ST_OK;
    case (op_q)
      OP_RESERVE: begin
        if (found_q) begin
          row_d[id_c] = 1'b1;
          cnt_d       = cnt_c + CNT_W'(1);
          ptr_d       = id_c;
          out_id_d    = CNT_W'(id_c);
        end else begin
          out_id_d = CNT_W'(IDS_PER_BANK);
          out_st_d = ST_FULL;
        end
      end
      OP_RELEASE: begin
        if (row_c[rid_q]) begin
          row_d[rid_q] = 1'b0;
          if (cnt_c != '0) begin
            cnt_d = cnt_c - CNT_W'(1);
          end
        end else begin
          out_st_d = ST_UNUSED;
        end
      end
      default: out_st_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BANKS; b++) begin
        map_q[b] <= '0;
        ptr_q[b] <= '0;
        cnt_q[b] <= '0;
      end
    end else if (cmd_i.commit) begin
      map_q[bank_q] <= row_d;
      ptr_q[bank_q] <= ptr_d;
      cnt_q[bank_q] <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      bank_q  <= bank_sel;
      rid_q   <= rid_s;
      found_q <= found_s;
      grp_q   <= grp_s;
      gbits_q <= gbits_s;
    end
    if (cmd_i.commit) begin
      out_id_q  <= out_id_d;
      out_st_q  <= out_st_d;
      out_cnt_q <= cnt_d;
    end
  end

  assign granted_id_o   = out_id_q;
  assign status_o       = out_st_q;
  assign in_use_count_o = out_cnt_q;

endmodule

/* design/banked_next_fit_id_allocator_top.sv */
// top level of the banked next-fit id allocator
//
// Requests enter on the input channel (operation_i, bank_i, release_id_i)
// with in_valid_i / in_stall_o; one result per request leaves on the output
// channel (granted_id_o, status_o, in_use_count_o) with out_valid_o /
// out_stall_i. An item moves when valid is high and stall is low.
// A reserve takes the first free id at or above the bank's search pointer,
// wrapping around; a full bank gives id IDS_PER_BANK and status full.
// A release frees the id, or reports status unused if it was free.
// The item is registered when it is accepted, its result when it commits.
// No new item is taken until the last one has committed; the free-id
// search over the bank bitmap runs in the accept cycle, the update at commit.
// While a result waits under out_stall_i the next item can be accepted,
// and it then holds in its commit cycle until the result is taken.
// Reset frees every id and clears pointers and counts; no clearing pass.
module banked_next_fit_id_allocator_top #(
  parameter int  IDS_PER_BANK = bnfa_pkg::IDS_PER_BANK_DEF,
  parameter int  BANKS        = bnfa_pkg::BANKS_DEF,
  localparam int ID_W         = $clog2(IDS_PER_BANK),
  localparam int CNT_W        = ID_W + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic                          bank_i,
  input  logic [ID_W-1:0]               release_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [CNT_W-1:0]              granted_id_o,
  output logic [bnfa_pkg::STATUS_W-1:0] status_o,
  output logic [CNT_W-1:0]              in_use_count_o
);
  import bnfa_pkg::*;

  ctrl_cmd_t cmd;

  bnfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  bnfa_datapath #(
    .IDS_PER_BANK (IDS_PER_BANK),
    .BANKS        (BANKS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operation_i    (operation_i),
    .bank_i         (bank_i),
    .release_id_i   (release_id_i),
    .granted_id_o   (granted_id_o),
    .status_o       (status_o),
    .in_use_count_o (in_use_count_o)
  );

endmodule

/* tb/sv/tb_banked_next_fit_id_allocator_top.sv */
// self-checking testbench for the banked next-fit id allocator with its own allocation predictor
module tb_banked_next_fit_id_allocator_top;
  import bnfa_pkg::*;

  localparam int IDS       = IDS_PER_BANK_DEF;
  localparam int NBANKS    = BANKS_DEF;
  localparam int ID_W      = $clog2(IDS);
  localparam int CNT_W     = ID_W + 1;
  localparam int MAX_CYCLE = 300000;

  typedef struct packed {
    logic [CNT_W-1:0]    id;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
  } grant_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                operation_i;
  logic                bank_i;
  logic [ID_W-1:0]     release_id_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CNT_W-1:0]    granted_id_o;
  logic [STATUS_W-1:0] status_o;
  logic [CNT_W-1:0]    in_use_count_o;

  logic [IDS-1:0]   id_taken   [NBANKS];
  logic [ID_W-1:0]  next_ptr   [NBANKS];
  logic [CNT_W-1:0] bank_count [NBANKS];
  grant_t           pending_grants[$];

  int mismatches;
  int cycles;
  int in_gap_max;
  int out_gap_max;
  int hold_off_cycles;

  banked_next_fit_id_allocator_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .bank_i         (bank_i),
    .release_id_i   (release_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_id_o   (granted_id_o),
    .status_o       (status_o),
    .in_use_count_o (in_use_count_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_banked_next_fit_id_allocator_top: FAIL");
      $finish;
    end
  end

  // next-fit allocation over the predictor's own bitmaps
  function automatic grant_t apply_request(logic op, logic bnk, logic [ID_W-1:0] rid);
    grant_t          g;
    logic [ID_W-1:0] p;
    logic            found;
    g.id     = CNT_W'(rid);
    g.status = ST_UNUSED;
    found    = 1'b0;
    if (op == OP_RESERVE) begin
      p        = next_ptr[bnk];
      g.id     = CNT_W'(IDS);
      g.status = ST_FULL;
      for (int n = 0; n < IDS; n++) begin
        if (!found && !id_taken[bnk][p]) begin
          found             = 1'b1;
          id_taken[bnk][p]  = 1'b1;
          bank_count[bnk]   = bank_count[bnk] + CNT_W'(1);
          next_ptr[bnk]     = p;
          g.id              = CNT_W'(p);
          g.status          = ST_OK;
        end
        if (!found) p = p + ID_W'(1);
      end
    end else if (id_taken[bnk][rid]) begin
      id_taken[bnk][rid] = 1'b0;
      if (bank_count[bnk] != '0) bank_count[bnk] = bank_count[bnk] - CNT_W'(1);
      g.status = ST_OK;
    end
    g.count = bank_count[bnk];
    return g;
  endfunction

  function automatic logic [ID_W-1:0] pick_taken_id(logic bnk);
    logic [ID_W-1:0] p;
    logic            found;
    p     = ID_W'($urandom);
    found = 1'b0;
    for (int n = 0; n < IDS; n++) begin
      if (!found && id_taken[bnk][p]) found = 1'b1;
      if (!found) p = p + ID_W'(1);
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  task automatic send_request(logic op, logic bnk, logic [ID_W-1:0] rid);
    int gap;
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    bank_i       <= bnk;
    release_id_i <= rid;
    do @(posedge clk_i); while (in_stall_o);
    pending_grants.push_back(apply_request(op, bnk, rid));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    grant_t g;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("unexpected item, granted_id", granted_id_o, -1);
      end else begin
        g = pending_grants.pop_front();
        if (granted_id_o !== g.id) report_mismatch("granted_id", granted_id_o, g.id);
        if (status_o !== g.status) report_mismatch("status", status_o, g.status);
        if (in_use_count_o !== g.count)
          report_mismatch("in_use_count", in_use_count_o, g.count);
      end
    end
  end

  // receiver: random stall per item, plus a long hold-off on request
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        n = $urandom_range(out_gap_max, 0);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic test_reserve_and_release();
    send_request(OP_RESERVE, 1'b0, '0);
    send_request(OP_RESERVE, 1'b0, '1);
    send_request(OP_RESERVE, 1'b0, '0);
    send_request(OP_RELEASE, 1'b0, ID_W'(1));
    send_request(OP_RELEASE, 1'b0, ID_W'(1));
    send_request(OP_RESERVE, 1'b0, '0);
    send_request(OP_RELEASE, 1'b1, '1);
    send_request(OP_RELEASE, 1'b1, '0);
    send_request(OP_RESERVE, 1'b1, '0);
    send_request(OP_RESERVE, 1'b1, '1);
    send_request(OP_RELEASE, 1'b1, '0);
    send_request(OP_RESERVE, 1'b1, '0);
    send_request(OP_RELEASE, 1'b0, '0);
    send_request(OP_RELEASE, 1'b0, '1);
    send_request(OP_RESERVE, 1'b0, '0);
    send_request(OP_RESERVE, 1'b0, '0);
    settle();
  endtask

  task automatic test_bank_full();
    in_gap_max  = 2;
    out_gap_max = 2;
    while (bank_count[1] != CNT_W'(IDS)) send_request(OP_RESERVE, 1'b1, ID_W'($urandom));
    send_request(OP_RESERVE, 1'b1, '0);
    send_request(OP_RESERVE, 1'b1, '1);
    send_request(OP_RELEASE, 1'b1, ID_W'(64));
    send_request(OP_RESERVE, 1'b1, '0);
    send_request(OP_RESERVE, 1'b1, '0);
    send_request(OP_RELEASE, 1'b1, '1);
    send_request(OP_RELEASE, 1'b1, '0);
    send_request(OP_RESERVE, 1'b1, '0);
    for (int i = 0; i < IDS; i++) send_request(OP_RELEASE, 1'b1, ID_W'(i));
    send_request(OP_RELEASE, 1'b1, ID_W'(5));
    send_request(OP_RESERVE, 1'b1, '0);
    settle();
  endtask

  task automatic test_input_backpressure();
    in_gap_max      = 0;
    out_gap_max     = 0;
    hold_off_cycles = 80;
    for (int i = 0; i < 30; i++) begin
      if ($urandom_range(1, 0) == 0) send_request(OP_RESERVE, 1'($urandom), ID_W'($urandom));
      else send_request(OP_RELEASE, 1'b0, pick_taken_id(1'b0));
    end
    settle();
  endtask

  task automatic test_random_traffic();
    int          reserve_pct [8] = '{90, 95, 50, 10, 5, 90, 95, 30};
    logic        fav;
    logic        bnk;
    logic [ID_W-1:0] rid;
    for (int ph = 0; ph < 8; ph++) begin
      fav         = 1'($urandom);
      in_gap_max  = ($urandom_range(2, 0) == 0) ? 0 : 10;
      out_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 10;
      for (int i = 0; i < 76; i++) begin
        bnk = ($urandom_range(99, 0) < 80) ? fav : 1'($urandom);
        if ($urandom_range(99, 0) < reserve_pct[ph]) begin
          send_request(OP_RESERVE, bnk, ID_W'($urandom));
        end else begin
          rid = ($urandom_range(3, 0) != 0) ? pick_taken_id(bnk) : ID_W'($urandom);
          send_request(OP_RELEASE, bnk, rid);
        end
      end
    end
    settle();
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    operation_i     = OP_RESERVE;
    bank_i          = 1'b0;
    release_id_i    = '0;
    mismatches      = 0;
    cycles          = 0;
    in_gap_max      = 10;
    out_gap_max     = 10;
    hold_off_cycles = 0;
    for (int b = 0; b < NBANKS; b++) begin
      id_taken[b]   = '0;
      next_ptr[b]   = '0;
      bank_count[b] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reserve_and_release();
    test_bank_full();
    test_input_backpressure();
    test_random_traffic();

    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_banked_next_fit_id_allocator_top: PASS");
    end else begin
      $display("tb_banked_next_fit_id_allocator_top: FAIL");
    end
    $finish;
  end

endmodule
